// ===== rtl/core/sdfb_pkg.sv =====
// Shared types and constants for the debug frame builder.
package sdfb_pkg;

  // Request kinds carried on the input tuser field
  localparam logic [1:0] OP_BEGIN   = 2'd0;
  localparam logic [1:0] OP_PAYLOAD = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Filler byte used for header padding and payload alignment
  localparam logic [7:0] PAD_BYTE = 8'hff;

  // Index of the final header byte
  localparam logic [3:0] HDR_LAST_IDX = 4'd15;

  // One burst of output bytes, as handed from the state logic to the emitter
  typedef struct packed {
    logic        is_header;   // 16-byte header burst, else payload byte plus padding
    logic [31:0] frame_num;   // frame number snapshot for the header
    logic [15:0] length;      // saturated payload length for the header
    logic [7:0]  data;        // payload byte
    logic [1:0]  num_pad;     // pad bytes after the payload byte
    logic        frame_end;   // final byte of this burst closes the frame
  } burst_t;

endpackage

// ===== rtl/core/sdfb_emit.sv =====
// Burst register and byte emitter with registered stream output.
module sdfb_emit
  import sdfb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // burst hand-over from the state logic
  input  logic         load_i,
  input  burst_t       burst_i,
  output logic         take_o,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,   // [7:0] out_byte
  output logic         m_axis_tlast,
  output logic         m_axis_tuser    // [0] frame_end
);

  logic         burst_valid_q;
  burst_t       burst_q;
  logic [3:0]   idx_q;
  logic         out_valid_q;
  logic [7:0]   out_byte_q;
  logic         out_last_q;
  logic         out_fend_q;

  logic         out_load;
  logic         is_last;
  logic         finish;
  logic [7:0]   cur_byte;

  // Final byte of the held burst
  always_comb begin
    if (burst_q.is_header) begin
      is_last = (idx_q == HDR_LAST_IDX);
    end else begin
      is_last = (idx_q[1:0] == burst_q.num_pad);
    end
  end

  // Byte at the current position of the burst
  always_comb begin
    if (burst_q.is_header) begin
      case (idx_q)
        4'd4:    cur_byte = burst_q.frame_num[7:0];
        4'd5:    cur_byte = burst_q.frame_num[15:8];
        4'd6:    cur_byte = burst_q.frame_num[23:16];
        4'd7:    cur_byte = burst_q.frame_num[31:24];
        4'd8:    cur_byte = burst_q.length[7:0];
        4'd9:    cur_byte = burst_q.length[15:8];
        4'd10:   cur_byte = 8'h00;
        4'd11:   cur_byte = 8'h00;
        default: cur_byte = PAD_BYTE;
      endcase
    end else begin
      cur_byte = (idx_q == 4'd0) ? burst_q.data : PAD_BYTE;
    end
  end

  assign out_load = burst_valid_q && (!out_valid_q || m_axis_tready);
  assign finish   = out_load && is_last;
  assign take_o   = !burst_valid_q || finish;

  // Burst register and position counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_valid_q <= 1'b0;
      idx_q         <= 4'd0;
    end else if (load_i) begin
      burst_valid_q <= 1'b1;
      idx_q         <= 4'd0;
    end else if (finish) begin
      burst_valid_q <= 1'b0;
    end else if (out_load) begin
      idx_q <= idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q <= cur_byte;
      out_last_q <= is_last;
      out_fend_q <= is_last && burst_q.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_fend_q;

endmodule

// ===== rtl/core/spi_debug_frame_builder_unit.sv =====
// Top level of the debug frame builder: frame state and request decode.
//
//  Channel   Dir  Payload                                     Handshake
//  s_axis    in   tdata[15:0] frame_length, [23:16] data_byte  tvalid/tready
//                 tuser[1:0] op
//  m_axis    out  tdata[7:0] out_byte, tuser[0] frame_end,     tvalid/tready
//                 tlast = final byte of a request
//
// A payload request gives one byte, a request that closes a frame 1 to 4 bytes
// and a begin request 16 bytes, one a cycle while the output is not stalled,
// paced by the byte emitter. Requests with no output load no burst. A new
// request is taken while the last byte of the previous burst moves into the
// output register. Reset clears the frame number and closes any frame; a stalled
// output holds its byte and the emitter's burst until the sink takes them.
module spi_debug_frame_builder_unit
  import sdfb_pkg::*;
#(
  parameter logic [31:0] MAX_PAYLOAD_BYTES = 32'd65535
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // [15:0] frame_length, [23:16] data_byte
  input  logic [1:0]   s_axis_tuser,   // [1:0] op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,   // [7:0] out_byte
  output logic         m_axis_tlast,
  output logic         m_axis_tuser    // [0] frame_end
);

  logic [31:0]  frame_num_q, frame_num_d;
  logic [15:0]  remain_q, remain_d;
  logic [1:0]   pad_q, pad_d;
  logic         open_q, open_d;

  logic         take;
  logic         accept;
  logic         emit;
  burst_t       burst;
  logic [15:0]  len_sat;
  logic [15:0]  remain_dec;
  logic [1:0]   op;
  logic [15:0]  frame_length;
  logic [7:0]   data_byte;

  assign op           = s_axis_tuser;
  assign frame_length = s_axis_tdata[15:0];
  assign data_byte    = s_axis_tdata[23:16];

  assign s_axis_tready = take;
  assign accept        = s_axis_tvalid && take;

  // Length clipped to the largest payload allowed
  assign len_sat    = ({16'd0, frame_length} > MAX_PAYLOAD_BYTES) ?
                      MAX_PAYLOAD_BYTES[15:0] : frame_length;
  assign remain_dec = remain_q - 16'd1;

  // Next frame state and the burst each request produces
  always_comb begin
    frame_num_d     = frame_num_q;
    remain_d        = remain_q;
    pad_d           = pad_q;
    open_d          = open_q;
    emit            = 1'b0;
    burst.is_header = 1'b0;
    burst.frame_num = frame_num_q;
    burst.length    = len_sat;
    burst.data      = data_byte;
    burst.num_pad   = 2'd0;
    burst.frame_end = 1'b0;
    case (op)
      OP_BEGIN: begin
        emit            = 1'b1;
        burst.is_header = 1'b1;
        if (len_sat == 16'd0) begin
          burst.frame_end = 1'b1;
          frame_num_d     = frame_num_q + 32'd1;
          open_d          = 1'b0;
          remain_d        = 16'd0;
          pad_d           = 2'd0;
        end else begin
          open_d   = 1'b1;
          remain_d = len_sat;
          pad_d    = 2'd0 - len_sat[1:0];
        end
      end
      OP_PAYLOAD: begin
        if (!open_q || remain_q == 16'd0) begin
          open_d = 1'b0;
        end else begin
          emit     = 1'b1;
          remain_d = remain_dec;
          if (remain_dec == 16'd0) begin
            burst.num_pad   = pad_q;
            burst.frame_end = 1'b1;
            frame_num_d     = frame_num_q + 32'd1;
            open_d          = 1'b0;
            pad_d           = 2'd0;
          end
        end
      end
      OP_RESTART: begin
        frame_num_d = 32'd0;
        open_d      = 1'b0;
        remain_d    = 16'd0;
        pad_d       = 2'd0;
      end
      default: begin
      end
    endcase
  end

  // Frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_num_q <= 32'd0;
      remain_q    <= 16'd0;
      pad_q       <= 2'd0;
      open_q      <= 1'b0;
    end else if (accept) begin
      frame_num_q <= frame_num_d;
      remain_q    <= remain_d;
      pad_q       <= pad_d;
      open_q      <= open_d;
    end
  end

  // Byte emitter and output register
  sdfb_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept && emit),
    .burst_i       (burst),
    .take_o        (take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
